[rtl/core/mpdm_pkg.sv]
// Shared types and constants for the multi-pattern digit matcher.
// No dependencies.
package mpdm_pkg;

   localparam int NODES_DEF    = 4096;
   localparam int ALPHABET_DEF = 10;
   localparam int DIGIT_W      = 4;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_BUILD   = 2'd1,
      OP_SCAN    = 2'd2,
      OP_RESTART = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_PHASE = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [DIGIT_W-1:0]   digit;
      logic                 pattern_end;
   } req_type;

   typedef struct packed {
      status_type status;
      logic       match;
   } res_type;

endpackage

[rtl/core/multi_pattern_digit_matcher.sv]
// Multi-pattern digit matcher (Aho-Corasick automaton), top level.
// Insert and scan read a goto row, then a node mark; restart and phase-rejected words go
// straight to the result. Build reads the root row, then each non-root node breadth-first.
// Throughput: one word at a time; the next is taken once the result is in the output register.
// Reset: synchronous; a clearing pass then zeroes goto rows and node marks, during which
// no word is taken. Depends on mpdm_pkg and mpdm_engine.
module multi_pattern_digit_matcher #(
   parameter int NODES    = mpdm_pkg::NODES_DEF,
   parameter int ALPHABET = mpdm_pkg::ALPHABET_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [mpdm_pkg::DIGIT_W-1:0]  req_digit,
   input  logic                          req_pattern_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [$clog2(NODES)-1:0]      rsp_node,
   output logic                          rsp_match
);
   localparam int NW = $clog2(NODES);

   logic               eng_idle, eng_done, room;
   mpdm_pkg::req_type  eng_req;
   mpdm_pkg::res_type  eng_res;
   logic [NW-1:0]      eng_node;

   // output register: holds one finished word while the engine runs on
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [NW-1:0]      rsp_node_ff;
   logic               rsp_match_ff;

   assign eng_req.opcode      = mpdm_pkg::opcode_type'(req_opcode);
   assign eng_req.digit       = req_digit;
   assign eng_req.pattern_end = req_pattern_end;

   assign room      = !rsp_valid_ff || rsp_ready;
   assign req_ready = eng_idle;

   mpdm_engine #(.NODES(NODES), .ALPHABET(ALPHABET)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && eng_idle),
      .req      (eng_req),
      .idle     (eng_idle),
      .room     (room),
      .done     (eng_done),
      .res      (eng_res),
      .res_node (eng_node)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done) begin
         rsp_status_ff <= eng_res.status;
         rsp_node_ff   <= eng_node;
         rsp_match_ff  <= eng_res.match;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_match  = rsp_match_ff;

endmodule

[rtl/core/mpdm_engine.sv]
// Automaton engine: goto, node and queue memories plus the sequencer.
// Depends on mpdm_pkg.
module mpdm_engine #(
   parameter int NODES    = mpdm_pkg::NODES_DEF,
   parameter int ALPHABET = mpdm_pkg::ALPHABET_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mpdm_pkg::req_type      req,
   output logic                   idle,
   input  logic                   room,
   output logic                   done,
   output mpdm_pkg::res_type      res,
   output logic [$clog2(NODES)-1:0] res_node
);
   localparam int NW = $clog2(NODES);
   localparam int DW = $clog2(ALPHABET);
   localparam int CW = NW + 1;

   typedef logic [ALPHABET-1:0][NW-1:0] row_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_INS_ROW, S_INS_NODE, S_SCN_ROW, S_SCN_NODE,
      S_B_ROOT, S_B_DEQ, S_B_U, S_B_F, S_B_LOOP, S_B_WB, S_RESP
   } state_type;

   // memories
   row_type       gmem [NODES];
   logic [NW:0]   nmem [NODES];   // {end mark, fail link}
   logic [NW-1:0] qmem [NODES];

   row_type       g_rd_ff;
   logic [NW:0]   n_rd_ff;
   logic [NW-1:0] q_rd_ff;

   logic          g_re, g_we, n_re, n_we_end, n_we_fail, q_re, q_we;
   logic [NW-1:0] g_ra, g_wa, n_ra, n_wa, n_wfail, q_ra, q_wa, q_wd;
   row_type       g_wd;
   logic          n_wend;

   state_type          state_ff;
   logic               built_ff;
   logic [NW-1:0]      cursor_ff, scan_ff, count_ff, clr_ff, u_ff, node_ff;
   logic [CW-1:0]      head_ff, tail_ff;
   logic [DW-1:0]      bcnt_ff;
   logic               endu_ff;
   row_type            rowu_ff;
   mpdm_pkg::req_type  req_ff;
   mpdm_pkg::res_type  res_ff;

   logic          dig_in_ok, bcnt_last, ins_new, ins_full, tail_room;
   logic [DW-1:0] dsel;
   logic [NW-1:0] ins_raw, ins_nxt, loop_c, loop_f, root_c;
   row_type       row_ins;

   always_comb begin
      dig_in_ok = (32'(req.digit) < ALPHABET);
      dsel      = DW'(req_ff.digit);
      bcnt_last = (bcnt_ff == DW'(ALPHABET - 1));
      ins_raw   = g_rd_ff[dsel];
      ins_new   = (ins_raw == '0);
      ins_full  = ((CW'(count_ff) + CW'(1)) >= CW'(NODES));
      ins_nxt   = ins_new ? (count_ff + NW'(1)) : ins_raw;
      row_ins   = g_rd_ff;
      row_ins[dsel] = ins_nxt;
      loop_c    = rowu_ff[bcnt_ff];
      loop_f    = g_rd_ff[bcnt_ff];
      root_c    = g_rd_ff[bcnt_ff];
      tail_room = (tail_ff < CW'(NODES));
   end

   // memory port control
   always_comb begin
      g_re = 1'b0; g_ra = '0; g_we = 1'b0; g_wa = '0; g_wd = '0;
      n_re = 1'b0; n_ra = '0; n_we_end = 1'b0; n_we_fail = 1'b0;
      n_wa = '0; n_wend = 1'b0; n_wfail = '0;
      q_re = 1'b0; q_ra = '0; q_we = 1'b0; q_wa = '0; q_wd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            g_we = 1'b1; g_wa = clr_ff;
            n_we_end = 1'b1; n_we_fail = 1'b1; n_wa = clr_ff;
         end
         S_IDLE: begin
            g_re = start;
            priority case (req.opcode)
               mpdm_pkg::OP_INSERT: g_ra = cursor_ff;
               mpdm_pkg::OP_SCAN:   g_ra = scan_ff;
               default:             g_ra = '0;
            endcase
         end
         S_INS_ROW: begin
            g_we = ins_new && !ins_full; g_wa = cursor_ff; g_wd = row_ins;
            n_re = 1'b1; n_ra = ins_nxt;
         end
         S_INS_NODE: begin
            n_we_end = req_ff.pattern_end; n_wa = node_ff; n_wend = 1'b1;
         end
         S_SCN_ROW: begin
            n_re = 1'b1; n_ra = ins_raw;
         end
         S_B_ROOT: begin
            q_we = (root_c != '0) && tail_room;
            q_wa = tail_ff[NW-1:0]; q_wd = root_c;
         end
         S_B_DEQ: begin
            q_re = (head_ff < tail_ff); q_ra = head_ff[NW-1:0];
         end
         S_B_U: begin
            g_re = 1'b1; g_ra = q_rd_ff;
            n_re = 1'b1; n_ra = q_rd_ff;
         end
         S_B_F: begin
            g_re = 1'b1; g_ra = n_rd_ff[NW-1:0];
            n_re = 1'b1; n_ra = n_rd_ff[NW-1:0];
         end
         S_B_LOOP: begin
            n_we_fail = (loop_c != '0); n_wa = loop_c; n_wfail = loop_f;
            q_we = (loop_c != '0) && tail_room;
            q_wa = tail_ff[NW-1:0]; q_wd = loop_c;
         end
         S_B_WB: begin
            g_we = 1'b1; g_wa = u_ff; g_wd = rowu_ff;
            n_we_end = 1'b1; n_wa = u_ff; n_wend = endu_ff | n_rd_ff[NW];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (g_we) gmem[g_wa] <= g_wd;
      if (g_re) g_rd_ff <= gmem[g_ra];
      if (n_we_end)  nmem[n_wa][NW] <= n_wend;
      if (n_we_fail) nmem[n_wa][NW-1:0] <= n_wfail;
      if (n_re) n_rd_ff <= nmem[n_ra];
      if (q_we) qmem[q_wa] <= q_wd;
      if (q_re) q_rd_ff <= qmem[q_ra];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         built_ff  <= 1'b0;
         cursor_ff <= '0;
         scan_ff   <= '0;
         count_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         bcnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + NW'(1);
               if (clr_ff == NW'(NODES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  req_ff       <= req;
                  node_ff      <= '0;
                  res_ff.match <= 1'b0;
                  unique case (req.opcode)
                     mpdm_pkg::OP_INSERT: begin
                        if (built_ff || !dig_in_ok) begin
                           res_ff.status <= mpdm_pkg::ST_PHASE;
                           state_ff      <= S_RESP;
                        end else begin
                           res_ff.status <= mpdm_pkg::ST_OK;
                           state_ff      <= S_INS_ROW;
                        end
                     end
                     mpdm_pkg::OP_BUILD: begin
                        if (built_ff) begin
                           res_ff.status <= mpdm_pkg::ST_PHASE;
                           state_ff      <= S_RESP;
                        end else begin
                           res_ff.status <= mpdm_pkg::ST_OK;
                           head_ff  <= '0;
                           tail_ff  <= '0;
                           bcnt_ff  <= '0;
                           state_ff <= S_B_ROOT;
                        end
                     end
                     mpdm_pkg::OP_SCAN: begin
                        if (!built_ff || !dig_in_ok) begin
                           res_ff.status <= mpdm_pkg::ST_PHASE;
                           state_ff      <= S_RESP;
                        end else begin
                           res_ff.status <= mpdm_pkg::ST_OK;
                           state_ff      <= S_SCN_ROW;
                        end
                     end
                     mpdm_pkg::OP_RESTART: begin
                        res_ff.status <= mpdm_pkg::ST_OK;
                        scan_ff  <= '0;
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_INS_ROW: begin
               if (ins_new && ins_full) begin
                  res_ff.status <= mpdm_pkg::ST_FULL;
                  state_ff      <= S_RESP;
               end else begin
                  if (ins_new) count_ff <= count_ff + NW'(1);
                  node_ff   <= ins_nxt;
                  cursor_ff <= req_ff.pattern_end ? '0 : ins_nxt;
                  state_ff  <= S_INS_NODE;
               end
            end
            S_INS_NODE: begin
               res_ff.match <= req_ff.pattern_end | n_rd_ff[NW];
               state_ff     <= S_RESP;
            end
            S_SCN_ROW: begin
               scan_ff  <= ins_raw;
               node_ff  <= ins_raw;
               state_ff <= S_SCN_NODE;
            end
            S_SCN_NODE: begin
               res_ff.match <= n_rd_ff[NW];
               state_ff     <= S_RESP;
            end
            S_B_ROOT: begin
               if ((root_c != '0) && tail_room) tail_ff <= tail_ff + CW'(1);
               bcnt_ff <= bcnt_ff + DW'(1);
               if (bcnt_last) state_ff <= S_B_DEQ;
            end
            S_B_DEQ: begin
               if (head_ff < tail_ff) begin
                  head_ff  <= head_ff + CW'(1);
                  state_ff <= S_B_U;
               end else begin
                  built_ff  <= 1'b1;
                  cursor_ff <= '0;
                  state_ff  <= S_RESP;
               end
            end
            S_B_U: begin
               u_ff     <= q_rd_ff;
               state_ff <= S_B_F;
            end
            S_B_F: begin
               rowu_ff  <= g_rd_ff;
               endu_ff  <= n_rd_ff[NW];
               bcnt_ff  <= '0;
               state_ff <= S_B_LOOP;
            end
            S_B_LOOP: begin
               if (loop_c == '0) rowu_ff[bcnt_ff] <= loop_f;
               else if (tail_room) tail_ff <= tail_ff + CW'(1);
               bcnt_ff <= bcnt_ff + DW'(1);
               if (bcnt_last) state_ff <= S_B_WB;
            end
            S_B_WB: state_ff <= S_B_DEQ;
            S_RESP: begin
               if (room) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign idle     = (state_ff == S_IDLE);
   assign done     = (state_ff == S_RESP) && room;
   assign res      = res_ff;
   assign res_node = node_ff;

endmodule

[test/multi_pattern_digit_matcher_checker.sv]
// Checker for the multi-pattern digit matcher: watches both channels, keeps its own
// copy of the trie and automaton, and compares each result word. Depends on mpdm_pkg.
module multi_pattern_digit_matcher_checker #(
   parameter int NODES    = mpdm_pkg::NODES_DEF,
   parameter int ALPHABET = mpdm_pkg::ALPHABET_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [mpdm_pkg::DIGIT_W-1:0]  req_digit,
   input  logic                          req_pattern_end,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_status,
   input  logic [$clog2(NODES)-1:0]      rsp_node,
   input  logic                          rsp_match,
   output int                            fail_count,
   output int                            pending
);
   localparam int NODE_W = $clog2(NODES);

   typedef struct {
      mpdm_pkg::status_type status;
      logic [NODE_W-1:0]    node;
      logic                 match;
   } matcher_word_type;

   logic [NODE_W-1:0] trie_edge [NODES*ALPHABET];
   logic [NODE_W-1:0] fail_of [NODES];
   logic              marked [NODES];
   int                used_nodes;
   int                cursor;
   int                scan_at;
   logic              linked;
   matcher_word_type  expected_words [$];

   // breadth-first pass: fill missing edges through fail links, OR marks down
   function automatic void link_trie();
      int order [$];
      int u, f, c;
      for (int d = 0; d < ALPHABET; d++)
         if (trie_edge[d] != 0) order.push_back(int'(trie_edge[d]));
      for (int h = 0; h < order.size(); h++) begin
         u = order[h];
         f = int'(fail_of[u]);
         for (int d = 0; d < ALPHABET; d++) begin
            c = int'(trie_edge[u*ALPHABET+d]);
            if (c == 0) begin
               trie_edge[u*ALPHABET+d] = trie_edge[f*ALPHABET+d];
            end else begin
               fail_of[c] = trie_edge[f*ALPHABET+d];
               order.push_back(c);
            end
         end
         marked[u] = marked[u] | marked[f];
      end
   endfunction

   function automatic matcher_word_type step_matcher(logic [1:0] op, int digit, logic pend);
      matcher_word_type w;
      int nxt;
      w.status = mpdm_pkg::ST_OK;
      w.node   = '0;
      w.match  = 1'b0;
      unique case (mpdm_pkg::opcode_type'(op))
         mpdm_pkg::OP_INSERT: begin
            if (linked || digit >= ALPHABET) begin
               w.status = mpdm_pkg::ST_PHASE;
            end else begin
               nxt = int'(trie_edge[cursor*ALPHABET+digit]);
               if (nxt == 0) begin
                  if (used_nodes + 1 >= NODES) begin
                     w.status = mpdm_pkg::ST_FULL;
                  end else begin
                     used_nodes++;
                     nxt = used_nodes;
                     trie_edge[cursor*ALPHABET+digit] = NODE_W'(nxt);
                  end
               end
               if (w.status == mpdm_pkg::ST_OK) begin
                  if (pend) begin
                     marked[nxt] = 1'b1;
                     cursor = 0;
                  end else begin
                     cursor = nxt;
                  end
                  w.node  = NODE_W'(nxt);
                  w.match = marked[nxt];
               end
            end
         end
         mpdm_pkg::OP_BUILD: begin
            if (linked) begin
               w.status = mpdm_pkg::ST_PHASE;
            end else begin
               link_trie();
               linked = 1'b1;
               cursor = 0;
            end
         end
         mpdm_pkg::OP_SCAN: begin
            if (!linked || digit >= ALPHABET) begin
               w.status = mpdm_pkg::ST_PHASE;
            end else begin
               scan_at = int'(trie_edge[scan_at*ALPHABET+digit]);
               w.node  = NODE_W'(scan_at);
               w.match = marked[scan_at];
            end
         end
         default: scan_at = 0;
      endcase
      return w;
   endfunction

   initial begin
      for (int i = 0; i < NODES*ALPHABET; i++) trie_edge[i] = '0;
      for (int i = 0; i < NODES; i++) begin
         fail_of[i] = '0;
         marked[i]  = 1'b0;
      end
      used_nodes = 0;
      cursor     = 0;
      scan_at    = 0;
      linked     = 1'b0;
      fail_count = 0;
   end

   assign pending = expected_words.size();

   always @(posedge clock) begin
      matcher_word_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_status != w.status) begin
                  $error("status: expected %0d, actual %0d", w.status, rsp_status);
                  fail_count++;
               end
               if (rsp_node != w.node) begin
                  $error("node: expected %0d, actual %0d", w.node, rsp_node);
                  fail_count++;
               end
               if (rsp_match != w.match) begin
                  $error("match: expected %0d, actual %0d", w.match, rsp_match);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_words.push_back(step_matcher(req_opcode, int'(req_digit), req_pattern_end));
      end
   end

endmodule

[test/multi_pattern_digit_matcher_test.sv]
// Testbench top for the multi-pattern digit matcher: drives insert, build, scan and
// restart words with random gaps. Depends on mpdm_pkg and the checker module.
module multi_pattern_digit_matcher_test;
   localparam int NODES    = mpdm_pkg::NODES_DEF;
   localparam int ALPHABET = mpdm_pkg::ALPHABET_DEF;
   localparam int DIGIT_W  = mpdm_pkg::DIGIT_W;
   localparam int NODE_W   = $clog2(NODES);
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int CHAIN_LEN   = 100;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_opcode;
   logic [DIGIT_W-1:0]  req_digit;
   logic                req_pattern_end;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_status;
   logic [NODE_W-1:0]   rsp_node;
   logic                rsp_match;
   int                  fail_count;
   int                  pending;
   int                  cycles;
   bit                  calm;      // stretch with no idling on either side

   // pattern store, flat: digits plus start/length per pattern, used for scan replay
   int pat_digit [$];
   int pat_start [$];
   int pat_len [$];

   multi_pattern_digit_matcher #(.NODES(NODES), .ALPHABET(ALPHABET)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_digit(req_digit), .req_pattern_end(req_pattern_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_node(rsp_node), .rsp_match(rsp_match)
   );

   multi_pattern_digit_matcher_checker #(.NODES(NODES), .ALPHABET(ALPHABET)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_digit(req_digit), .req_pattern_end(req_pattern_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_node(rsp_node), .rsp_match(rsp_match),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap draw: 0..18, none at all during a calm stretch
   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   // one word on the request channel, after a random gap
   task automatic send_word(mpdm_pkg::opcode_type op, int digit, bit pend);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode      <= op;
      req_digit       <= DIGIT_W'(digit);
      req_pattern_end <= pend;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      if ($urandom_range(0, 63) == 0) calm = ~calm;
   endtask

   task automatic insert_pattern(int len);
      int d;
      pat_start.push_back(pat_digit.size());
      pat_len.push_back(len);
      for (int i = 0; i < len; i++) begin
         d = $urandom_range(0, ALPHABET-1);
         pat_digit.push_back(d);
         send_word(mpdm_pkg::OP_INSERT, d, i == len-1);
      end
   endtask

   // receiver: stall a random number of cycles per word
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int p, k;
      calm            = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= mpdm_pkg::OP_RESTART;
      req_digit       <= '0;
      req_pattern_end <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: wrong-phase scan, restart in load phase, rejected digits
      send_word(mpdm_pkg::OP_SCAN, 3, 1'b0);
      send_word(mpdm_pkg::OP_RESTART, 0, 1'b0);
      send_word(mpdm_pkg::OP_INSERT, 15, 1'b1);
      send_word(mpdm_pkg::OP_INSERT, 10, 1'b0);
      // single-digit patterns at the digit extremes, then one repeated (already marked)
      send_word(mpdm_pkg::OP_INSERT, 0, 1'b1);
      send_word(mpdm_pkg::OP_INSERT, 9, 1'b1);
      send_word(mpdm_pkg::OP_INSERT, 9, 1'b1);
      // shared prefix: 9,0 walks an existing edge then adds one
      send_word(mpdm_pkg::OP_INSERT, 9, 1'b0);
      send_word(mpdm_pkg::OP_INSERT, 0, 1'b1);
      pat_start.push_back(0); pat_len.push_back(2);
      pat_digit.push_back(9); pat_digit.push_back(0);

      // random patterns with some noise
      for (int i = 0; i < 70; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_word(mpdm_pkg::opcode_type'($urandom_range(0, 1) ?
                      mpdm_pkg::OP_RESTART : mpdm_pkg::OP_INSERT),
                      $urandom_range(10, 15), $urandom_range(0, 1));
         insert_pattern($urandom_range(1, 6));
      end

      // one long chain, marked at its last digit
      for (int i = 0; i < CHAIN_LEN; i++)
         send_word(mpdm_pkg::OP_INSERT, $urandom_range(0, ALPHABET-1), i == CHAIN_LEN-1);
      // unfinished pattern left hanging when the links are built
      send_word(mpdm_pkg::OP_INSERT, 4, 1'b0);

      send_word(mpdm_pkg::OP_BUILD, 0, 1'b0);
      // directed, after build: second build, late insert, rejected scan digits
      send_word(mpdm_pkg::OP_BUILD, 0, 1'b0);
      send_word(mpdm_pkg::OP_INSERT, 2, 1'b1);
      send_word(mpdm_pkg::OP_SCAN, 15, 1'b0);
      send_word(mpdm_pkg::OP_SCAN, 10, 1'b1);
      send_word(mpdm_pkg::OP_SCAN, 0, 1'b0);
      send_word(mpdm_pkg::OP_SCAN, 9, 1'b0);

      // scanning: mostly pattern replays with random lead-in, some noise
      for (int i = 0; i < 300; i++) begin
         k = $urandom_range(0, 9);
         if (k == 0) begin
            send_word(mpdm_pkg::OP_RESTART, $urandom_range(0, 15), $urandom_range(0, 1));
         end else if (k == 1) begin
            send_word(mpdm_pkg::OP_SCAN, $urandom_range(0, 15), $urandom_range(0, 1));
         end else begin
            repeat ($urandom_range(0, 2))
               send_word(mpdm_pkg::OP_SCAN, $urandom_range(0, ALPHABET-1), 1'b0);
            p = $urandom_range(0, pat_start.size()-1);
            for (int j = 0; j < pat_len[p]; j++)
               send_word(mpdm_pkg::OP_SCAN, pat_digit[pat_start[p]+j], $urandom_range(0, 1));
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
